/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define QDS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define QDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/qds_pkg.sv */
// ----------------------------------------------------------------------------
// qds_pkg
// types and codes shared by the queue discipline scheduler and its channels
// ----------------------------------------------------------------------------
package qds_pkg;

	// fixed field widths
	localparam int TIME_W   = 32;
	localparam int SVC_W    = 16;
	localparam int ORDER_W  = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int POLICY_W = 2;

	// request operation codes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_DONE   = 1'b1;

	// selection policies, the unused code behaves as first come
	localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
	localparam logic [POLICY_W-1:0] POL_LCFS = 2'd1;
	localparam logic [POLICY_W-1:0] POL_SJF  = 2'd2;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_START  = 2'd0,
		ST_QUEUED = 2'd1,
		ST_DROP   = 2'd2,
		ST_IDLE   = 2'd3
	} status_t;

	// one waiting table entry
	typedef struct packed {
		logic               vld;
		logic [TIME_W-1:0]  arrival;
		logic [SVC_W-1:0]   service;
		logic [ORDER_W-1:0] order;
	} entry_t;

endpackage

/* rtl/qds_if.sv */
// ----------------------------------------------------------------------------
// qds_if
// valid/ready channels of the scheduler: job requests, results, policy writes
// ----------------------------------------------------------------------------

// job request channel
interface qds_job_if import qds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [TIME_W-1:0] event_time;
	logic [SVC_W-1:0]  service_time;

	modport source (output valid, output op, output event_time, output service_time,
		input ready);
	modport sink (input valid, input op, input event_time, input service_time,
		output ready);
endinterface

// result channel
interface qds_result_if import qds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [TIME_W-1:0]   delay;
	logic [TIME_W-1:0]   response_time;
	logic [TIME_W-1:0]   completion_time;
	logic [COUNT_W-1:0]  waiting_count;

	modport source (output valid, output status, output delay, output response_time,
		output completion_time, output waiting_count, input ready);
	modport sink (input valid, input status, input delay, input response_time,
		input completion_time, input waiting_count, output ready);
endinterface

// policy register write channel
interface qds_cfg_if import qds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [POLICY_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/queue_discipline_scheduler.sv */
// ----------------------------------------------------------------------------
// queue_discipline_scheduler: single-server job scheduler with a selectable queue policy
// steps: start or drop respond from decide; queued and idle after the table scan; a picked job adds calc and fin
// one request at a time, taken only in idle after the last result is loaded; the table scan reads one entry per cycle
// reset: asynchronous, then the table is cleared entry by entry with no request taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module queue_discipline_scheduler import qds_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	qds_cfg_if.sink       cfg,
	qds_job_if.sink       job,
	qds_result_if.source  result
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DECIDE, S_SCAN, S_INSERT, S_CALC, S_FIN, S_RESP
	} state_t;

	// saturating 32-bit add
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	state_t              state_q;
	logic [POLICY_W-1:0] policy_q;
	logic                busy_q;
	logic [CW-1:0]       job_count_q;
	logic [ORDER_W-1:0]  oc_q;

	// captured request
	logic                op_q;
	logic [TIME_W-1:0]   time_q;
	logic [SVC_W-1:0]    svc_q;

	// scan address and compare stage
	logic [IW-1:0]       addr_q;
	logic                issue_q;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	entry_t              rd_data_s1;

	// scan results
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	logic [TIME_W-1:0]   best_arr_q;
	logic [SVC_W-1:0]    best_svc_q;
	logic [ORDER_W-1:0]  best_age_q;

	// staged result and output register
	status_t             res_status_q;
	logic [TIME_W-1:0]   res_delay_q;
	logic [TIME_W-1:0]   res_rt_q;
	logic [TIME_W-1:0]   res_ct_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [TIME_W-1:0]   out_delay_q;
	logic [TIME_W-1:0]   out_rt_q;
	logic [TIME_W-1:0]   out_ct_q;
	logic [COUNT_W-1:0]  out_count_q;

	// table memory
	entry_t              mem [QUEUE_DEPTH];
	logic                mem_we;
	logic [IW-1:0]       mem_wa;
	entry_t              mem_wd;

	// shared compare unit
	logic [TIME_W-1:0]   key_e;
	logic [TIME_W-1:0]   key_b;
	logic [ORDER_W-1:0]  age_e;
	logic                key_lt;
	logic                key_eq;
	logic                better;

	assign cfg.ready = 1'b1;
	assign job.ready = (state_q == S_IDLE);

	assign result.valid           = out_valid_q;
	assign result.status          = out_status_q;
	assign result.delay           = out_delay_q;
	assign result.response_time   = out_rt_q;
	assign result.completion_time = out_ct_q;
	assign result.waiting_count   = out_count_q;

	// entry against current best under the policy, oldest wins a tie
	always_comb begin
		if (policy_q == POL_SJF) begin
			key_e = {{(TIME_W-SVC_W){1'b0}}, rd_data_s1.service};
			key_b = {{(TIME_W-SVC_W){1'b0}}, best_svc_q};
		end else begin
			key_e = rd_data_s1.arrival;
			key_b = best_arr_q;
		end
		key_lt = (policy_q == POL_LCFS) ? (key_b < key_e) : (key_e < key_b);
		key_eq = (key_e == key_b);
		age_e  = oc_q - rd_data_s1.order;
		better = key_lt || (key_eq && (age_e > best_age_q));
	end

	// table write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_INSERT: begin
				mem_we = 1'b1;
				mem_wa = free_idx_q;
				mem_wd = '{vld: 1'b1, arrival: time_q, service: svc_q, order: oc_q};
			end
			S_CALC: begin
				mem_we = found_q;
				mem_wa = best_idx_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_SCAN && issue_q) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			policy_q     <= POL_FCFS;
			busy_q       <= 1'b0;
			job_count_q  <= '0;
			oc_q         <= '0;
			op_q         <= OP_ARRIVE;
			time_q       <= '0;
			svc_q        <= '0;
			addr_q       <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_arr_q   <= '0;
			best_svc_q   <= '0;
			best_age_q   <= '0;
			res_status_q <= ST_IDLE;
			res_delay_q  <= '0;
			res_rt_q     <= '0;
			res_ct_q     <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_IDLE;
			out_delay_q  <= '0;
			out_rt_q     <= '0;
			out_ct_q     <= '0;
			out_count_q  <= '0;
		end else begin
			// policy register write
			if (cfg.valid) begin
				policy_q <= cfg.data;
			end

			// result taken downstream, a waiting result reloads it in S_RESP
			if (out_valid_q && result.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				// clear valid bits after reset
				S_CLEAR: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end

				// take a request
				S_IDLE: begin
					if (job.valid) begin
						op_q    <= job.op;
						time_q  <= job.event_time;
						svc_q   <= job.service_time;
						state_q <= S_DECIDE;
					end
				end

				// immediate cases, else start the scan
				S_DECIDE: begin
					res_delay_q  <= '0;
					addr_q       <= '0;
					issue_q      <= 1'b1;
					vld_s1       <= 1'b0;
					free_found_q <= 1'b0;
					found_q      <= 1'b0;
					if (op_q == OP_ARRIVE && !busy_q) begin
						busy_q       <= 1'b1;
						res_status_q <= ST_START;
						res_rt_q     <= {{(TIME_W-SVC_W){1'b0}}, svc_q};
						res_ct_q     <= sat_add(time_q, {{(TIME_W-SVC_W){1'b0}}, svc_q});
						state_q      <= S_RESP;
					end else if (op_q == OP_ARRIVE && job_count_q >= FULL_CNT) begin
						res_status_q <= ST_DROP;
						res_rt_q     <= '0;
						res_ct_q     <= '0;
						state_q      <= S_RESP;
					end else begin
						res_rt_q <= '0;
						res_ct_q <= '0;
						state_q  <= S_SCAN;
					end
				end

				// one entry per cycle through the compare unit
				S_SCAN: begin
					if (issue_q) begin
						idx_s1 <= addr_q;
						vld_s1 <= 1'b1;
						if (addr_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (op_q == OP_ARRIVE) begin
							if (!rd_data_s1.vld && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_s1;
							end
						end else if (rd_data_s1.vld && (!found_q || better)) begin
							found_q    <= 1'b1;
							best_idx_q <= idx_s1;
							best_arr_q <= rd_data_s1.arrival;
							best_svc_q <= rd_data_s1.service;
							best_age_q <= age_e;
						end
						if (idx_s1 == LAST_IDX) begin
							addr_q  <= '0;
							state_q <= (op_q == OP_ARRIVE) ? S_INSERT : S_CALC;
						end
					end
				end

				// store the arrival in the first free entry
				S_INSERT: begin
					oc_q         <= oc_q + 1'b1;
					job_count_q  <= job_count_q + 1'b1;
					res_status_q <= ST_QUEUED;
					state_q      <= S_RESP;
				end

				// retire the chosen entry, delay and completion time
				S_CALC: begin
					if (!found_q) begin
						busy_q       <= 1'b0;
						res_status_q <= ST_IDLE;
						state_q      <= S_RESP;
					end else begin
						busy_q <= 1'b1;
						if (job_count_q != '0) begin
							job_count_q <= job_count_q - 1'b1;
						end
						res_delay_q <= (time_q >= best_arr_q) ? (time_q - best_arr_q) : '0;
						res_ct_q    <= sat_add(time_q, {{(TIME_W-SVC_W){1'b0}}, best_svc_q});
						state_q     <= S_FIN;
					end
				end

				// response time from the registered delay
				S_FIN: begin
					res_status_q <= ST_START;
					res_rt_q     <= sat_add(res_delay_q, {{(TIME_W-SVC_W){1'b0}}, best_svc_q});
					state_q      <= S_RESP;
				end

				// load the output register once it is free
				S_RESP: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_delay_q  <= res_delay_q;
						out_rt_q     <= res_rt_q;
						out_ct_q     <= res_ct_q;
						out_count_q  <= COUNT_W'(job_count_q);
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// table never holds more than its depth
	`QDS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, job_count_q <= FULL_CNT)

	// only a started job carries times
	`QDS_ASSERT_NOW(a_times_zero, clk, arst_n,
		out_valid_q && (out_status_q != ST_START),
		(out_delay_q == '0) && (out_rt_q == '0) && (out_ct_q == '0))

	// the compare stage runs only inside a scan
	`QDS_ASSERT_NOW(a_scan_stage, clk, arst_n, vld_s1, state_q == S_SCAN)

endmodule

/* sim/qds_checker.sv */
// ----------------------------------------------------------------------------
// qds_checker
// watches the policy, job and result channels of the scheduler, predicts
// each result from its own copy of the waiting table and compares in order
// ----------------------------------------------------------------------------
module qds_checker import qds_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	qds_cfg_if          cfg,
	qds_job_if          job,
	qds_result_if       result,
	output int          mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// room for predicted results not yet returned
	localparam int DUE_SLOTS = 8;

	// one predicted result
	typedef struct {
		status_t             status;
		logic [TIME_W-1:0]   delay;
		logic [TIME_W-1:0]   response;
		logic [TIME_W-1:0]   finish;
		logic [COUNT_W-1:0]  waiting;
	} sched_outcome_t;

	// predicted scheduler state
	logic [TIME_W-1:0]   slot_arrival [QUEUE_DEPTH];
	logic [SVC_W-1:0]    slot_service [QUEUE_DEPTH];
	logic [ORDER_W-1:0]  slot_seq     [QUEUE_DEPTH];
	bit                  slot_used    [QUEUE_DEPTH];
	logic [ORDER_W-1:0]  seq_next;
	bit                  serving;
	int unsigned         waiting_jobs;
	logic [POLICY_W-1:0] rule;

	// predicted results in request order, oldest at due_head
	sched_outcome_t due_list [DUE_SLOTS];
	int unsigned    due_head;
	int unsigned    due_tail;

	initial mismatches = 0;

	function automatic logic [TIME_W-1:0] add_clamped(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	endfunction

	// true if slot i wins over slot j under the current rule, oldest on a tie
	function automatic bit prefers(input int i, input int j);
		logic [ORDER_W-1:0] age_i;
		logic [ORDER_W-1:0] age_j;
		age_i = seq_next - slot_seq[i];
		age_j = seq_next - slot_seq[j];
		case (rule)
			POL_LCFS: begin
				if (slot_arrival[i] != slot_arrival[j])
					return slot_arrival[i] > slot_arrival[j];
			end
			POL_SJF: begin
				if (slot_service[i] != slot_service[j])
					return slot_service[i] < slot_service[j];
			end
			default: begin
				if (slot_arrival[i] != slot_arrival[j])
					return slot_arrival[i] < slot_arrival[j];
			end
		endcase
		return age_i > age_j;
	endfunction

	// advance the predicted state by one request and return its result
	function automatic sched_outcome_t predict_outcome(input logic kind,
		input logic [TIME_W-1:0] stamp, input logic [SVC_W-1:0] demand);
		sched_outcome_t o;
		int pick;
		logic [TIME_W-1:0] wait_t;
		logic [TIME_W-1:0] svc_t;
		o.status   = ST_QUEUED;
		o.delay    = '0;
		o.response = '0;
		o.finish   = '0;
		pick = -1;
		if (kind == OP_ARRIVE) begin
			svc_t = TIME_W'(demand);
			if (!serving) begin
				serving    = 1'b1;
				o.status   = ST_START;
				o.response = svc_t;
				o.finish   = add_clamped(stamp, svc_t);
			end else if (waiting_jobs >= QUEUE_DEPTH) begin
				o.status = ST_DROP;
			end else begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (!slot_used[i] && pick < 0)
						pick = i;
				end
				slot_used[pick]    = 1'b1;
				slot_arrival[pick] = stamp;
				slot_service[pick] = demand;
				slot_seq[pick]     = seq_next;
				seq_next           = seq_next + 1'b1;
				waiting_jobs++;
			end
		end else begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (slot_used[i] && (pick < 0 || prefers(i, pick)))
					pick = i;
			end
			if (pick < 0) begin
				serving  = 1'b0;
				o.status = ST_IDLE;
			end else begin
				slot_used[pick] = 1'b0;
				waiting_jobs--;
				serving    = 1'b1;
				svc_t      = TIME_W'(slot_service[pick]);
				wait_t     = (stamp >= slot_arrival[pick]) ? stamp - slot_arrival[pick] : '0;
				o.status   = ST_START;
				o.delay    = wait_t;
				o.response = add_clamped(wait_t, svc_t);
				o.finish   = add_clamped(stamp, svc_t);
			end
		end
		o.waiting = COUNT_W'(waiting_jobs);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
		input logic [TIME_W-1:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// compare results first, then take policy writes and new requests
	always @(posedge clk or negedge arst_n) begin
		sched_outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				slot_used[i] = 1'b0;
			seq_next     = '0;
			serving      = 1'b0;
			waiting_jobs = 0;
			rule         = POL_FCFS;
			due_head     = 0;
			due_tail     = 0;
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (due_tail == due_head) begin
					report_mismatch("unrequested result status", result.status, '0);
				end else begin
					want = due_list[due_head % DUE_SLOTS];
					due_head++;
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
					if (result.delay !== want.delay)
						report_mismatch("delay", result.delay, want.delay);
					if (result.response_time !== want.response)
						report_mismatch("response_time", result.response_time, want.response);
					if (result.completion_time !== want.finish)
						report_mismatch("completion_time", result.completion_time, want.finish);
					if (result.waiting_count !== want.waiting)
						report_mismatch("waiting_count", result.waiting_count, want.waiting);
				end
			end
			if (cfg.valid && cfg.ready)
				rule = cfg.data;
			if (job.valid && job.ready) begin
				if (due_tail - due_head >= DUE_SLOTS)
					report_mismatch("result backlog", TIME_W'(due_tail - due_head), '0);
				due_list[due_tail % DUE_SLOTS] = predict_outcome(job.op, job.event_time,
					job.service_time);
				due_tail++;
			end
			outstanding <= due_tail - due_head;
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives job requests and policy writes into the scheduler with random gaps
// and result stalls; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module testbench import qds_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;

	int          fail_count;
	int unsigned due_count;
	int          quiet_cycles = 0;
	bit          steady_sender;
	logic [TIME_W-1:0] clock_now;

	qds_cfg_if    cfg_ch ();
	qds_job_if    job_ch ();
	qds_result_if res_ch ();

	queue_discipline_scheduler #(.QUEUE_DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.job    (job_ch),
		.result (res_ch)
	);

	qds_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.job         (job_ch),
		.result      (res_ch),
		.mismatches  (fail_count),
		.outstanding (due_count)
	);

	always #5 clk = ~clk;

	// offer one request, with a random gap unless the sender runs steady
	task automatic offer_request(input logic kind, input logic [TIME_W-1:0] stamp,
		input logic [SVC_W-1:0] demand);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			job_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		job_ch.valid        <= 1'b1;
		job_ch.op           <= kind;
		job_ch.event_time   <= stamp;
		job_ch.service_time <= demand;
		do @(posedge clk); while (!job_ch.ready);
	endtask

	// stop offering until every predicted result has come back
	task automatic drain_results();
		job_ch.valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	task automatic set_policy(input logic [POLICY_W-1:0] value);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: random stalls, calm stretches and two long hold-offs
	initial begin
		int stall;
		int taken;
		taken = 0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 400 || taken == 1400)
				stall = HOLD_CYCLES;
			else if ((taken / 150) % 3 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, 18);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
		end
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		int arrival_pct [PHASES];
		int roll;
		logic kind;
		logic [SVC_W-1:0] demand;
		arrival_pct = '{85, 25, 55, 90, 15, 50, 80, 30};
		arst_n              = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = POL_FCFS;
		job_ch.valid        = 1'b0;
		job_ch.op           = OP_ARRIVE;
		job_ch.event_time   = '0;
		job_ch.service_time = '0;
		steady_sender       = 1'b0;
		clock_now           = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// first come: completion while idle, ties, early completion, saturation
		set_policy(POL_FCFS);
		offer_request(OP_DONE,   32'd0,          16'd0);
		offer_request(OP_ARRIVE, 32'd0,          16'd0);
		offer_request(OP_ARRIVE, 32'd5,          16'hFFFF);
		offer_request(OP_ARRIVE, 32'd5,          16'd10);
		offer_request(OP_ARRIVE, 32'd3,          16'd10);
		offer_request(OP_DONE,   32'd2,          16'd0);
		offer_request(OP_DONE,   32'd100,        16'd0);
		offer_request(OP_ARRIVE, 32'hFFFF_FFF0,  16'hFFFF);
		offer_request(OP_DONE,   32'hFFFF_FFFF,  16'd0);
		offer_request(OP_DONE,   32'hFFFF_FFFF,  16'd0);
		offer_request(OP_DONE,   32'hFFFF_FFFF,  16'd0);
		offer_request(OP_ARRIVE, 32'hFFFF_FFFF,  16'hFFFF);

		// last come with a tie on arrival
		set_policy(POL_LCFS);
		offer_request(OP_ARRIVE, 32'd10, 16'd7);
		offer_request(OP_ARRIVE, 32'd10, 16'd3);
		offer_request(OP_ARRIVE, 32'd20, 16'd5);
		offer_request(OP_DONE,   32'd30, 16'd0);
		offer_request(OP_DONE,   32'd40, 16'd0);
		offer_request(OP_DONE,   32'd50, 16'd0);

		// shortest job with a tie on service
		set_policy(POL_SJF);
		offer_request(OP_ARRIVE, 32'd60, 16'd4);
		offer_request(OP_ARRIVE, 32'd61, 16'd4);
		offer_request(OP_ARRIVE, 32'd62, 16'd1);
		offer_request(OP_DONE,   32'd70, 16'd0);
		offer_request(OP_DONE,   32'd80, 16'd0);
		offer_request(OP_DONE,   32'd90, 16'd0);
		offer_request(OP_DONE,   32'd99, 16'd0);

		// random phases: each policy incl. the unused code, varied arrival mix
		clock_now = 32'd100;
		for (int p = 0; p < PHASES; p++) begin
			set_policy(POLICY_W'(p % 4));
			steady_sender = (p % 3 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = ($urandom_range(0, 99) < arrival_pct[p]) ? OP_ARRIVE : OP_DONE;
				// mostly small steps and ties, sometimes a jump anywhere
				roll = $urandom_range(0, 99);
				if (roll < 40)
					clock_now = clock_now;
				else if (roll < 85)
					clock_now = clock_now + $urandom_range(1, 20);
				else if (roll < 93)
					clock_now = clock_now + $urandom_range(0, 65535);
				else if (roll < 97)
					clock_now = $urandom;
				else
					clock_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
				roll = $urandom_range(0, 9);
				if (roll < 3)
					demand = SVC_W'($urandom_range(0, 7));
				else if (roll == 3)
					demand = '0;
				else if (roll == 4)
					demand = '1;
				else
					demand = SVC_W'($urandom_range(0, 65535));
				offer_request(kind, clock_now, demand);
			end
		end

		drain_results();
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qds_pkg.sv
rtl/qds_if.sv
rtl/queue_discipline_scheduler.sv
sim/qds_checker.sv
sim/testbench.sv
